FILE: rtl/ghash_pkg.sv
// shared types, constants and the gf(2^128) step function for the ghash accumulator
// no dependencies
`timescale 1ns / 1ps

package ghash_pkg;

   localparam int unsigned HalfWidth     = 64;
   localparam int unsigned BlockWidth    = 2 * HalfWidth;
   localparam int unsigned StepsPerCycle = 8;
   localparam int unsigned CycleCount    = BlockWidth / StepsPerCycle;
   localparam int unsigned CntWidth      = $clog2(CycleCount);
   localparam logic [CntWidth-1:0] CntLast = CntWidth'(CycleCount - 1);
   localparam logic [7:0] ReduceTop     = 8'hE1;

   localparam int unsigned CsrIndexWidth = 2;
   localparam logic [CsrIndexWidth-1:0] CsrSubkeyHigh = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrSubkeyLow  = 2'd1;

   typedef struct packed {
      logic [HalfWidth-1:0] block_high;
      logic [HalfWidth-1:0] block_low;
      logic                 last;
   } req_payload_type;

   typedef struct packed {
      logic [HalfWidth-1:0] digest_high;
      logic [HalfWidth-1:0] digest_low;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic finish;
      logic finish_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_blocked;
   } status_type;

   typedef struct packed {
      logic [BlockWidth-1:0] z;
      logic [BlockWidth-1:0] v;
   } gf_state_type;

   // eight shift-and-add steps, multiplier bits taken msb first
   function automatic gf_state_type gf_step8(gf_state_type s, logic [StepsPerCycle-1:0] xbits);
      gf_state_type r;
      logic         carry;
      r = s;
      for (int i = StepsPerCycle - 1; i >= 0; i--) begin
         carry = r.v[0];
         if (xbits[i]) begin
            r.z = r.z ^ r.v;
         end
         r.v = r.v >> 1;
         if (carry) begin
            r.v[BlockWidth-1 -: 8] = r.v[BlockWidth-1 -: 8] ^ ReduceTop;
         end
      end
      return r;
   endfunction

endpackage

FILE: rtl/ghash_ctrl.sv
// controller for the ghash accumulator: input handshake, step counter, finish
// depends on ghash_pkg
`timescale 1ns / 1ps

module ghash_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_last,
   input  ghash_pkg::status_type status,
   output ghash_pkg::cmd_type    cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type                         state_ff, state_in;
   logic [ghash_pkg::CntWidth-1:0]    cnt_ff, cnt_in;
   logic                              last_ff, last_in;
   logic                              at_end;
   logic                              can_finish;

   assign at_end     = (cnt_ff == ghash_pkg::CntLast);
   assign can_finish = !last_ff || !status.out_blocked;

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      last_in         = last_ff;
      req_ready       = 1'b0;
      cmd.load        = 1'b0;
      cmd.step        = 1'b0;
      cmd.finish      = 1'b0;
      cmd.finish_last = last_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               last_in  = req_last;
               cnt_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!at_end) begin
               cmd.step = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
            end else if (can_finish) begin
               // final byte of the multiplier and write-back in the same cycle
               cmd.step   = 1'b1;
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
      end
   end

endmodule

FILE: rtl/ghash_dp.sv
// datapath for the ghash accumulator: subkey, running hash, multiplier, output word
// depends on ghash_pkg
`timescale 1ns / 1ps

module ghash_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [ghash_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [ghash_pkg::HalfWidth-1:0]      csr_wdata,
   input  ghash_pkg::req_payload_type           req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output ghash_pkg::rsp_payload_type           rsp_payload,
   input  ghash_pkg::cmd_type                   cmd,
   output ghash_pkg::status_type                status
);

   localparam int unsigned BW = ghash_pkg::BlockWidth;
   localparam int unsigned SW = ghash_pkg::StepsPerCycle;

   logic [ghash_pkg::HalfWidth-1:0] key_high_ff, key_high_in;
   logic [ghash_pkg::HalfWidth-1:0] key_low_ff, key_low_in;
   logic [BW-1:0]                   acc_ff, acc_in;
   logic [BW-1:0]                   x_ff, x_in;
   ghash_pkg::gf_state_type         gf_ff, gf_in, gf_next;
   ghash_pkg::rsp_payload_type      out_ff, out_in;
   logic                            out_valid_ff, out_valid_in;

   assign gf_next            = ghash_pkg::gf_step8(gf_ff, x_ff[BW-1 -: SW]);
   assign status.out_blocked = out_valid_ff && !rsp_ready;
   assign rsp_valid          = out_valid_ff;
   assign rsp_payload        = out_ff;

   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      if (csr_wr_en) begin
         case (csr_index)
            ghash_pkg::CsrSubkeyHigh: key_high_in = csr_wdata;
            ghash_pkg::CsrSubkeyLow:  key_low_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      acc_in       = acc_ff;
      x_in         = x_ff;
      gf_in        = gf_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (cmd.load) begin
         x_in    = acc_ff ^ {req_payload.block_high, req_payload.block_low};
         gf_in.z = '0;
         gf_in.v = {key_high_ff, key_low_ff};
      end else if (cmd.step) begin
         x_in  = x_ff << SW;
         gf_in = gf_next;
      end
      if (cmd.finish) begin
         if (cmd.finish_last) begin
            out_in       = gf_next.z;
            out_valid_in = 1'b1;
            acc_in       = '0;
         end else begin
            acc_in = gf_next.z;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff  <= '0;
         key_low_ff   <= '0;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         key_high_ff  <= key_high_in;
         key_low_ff   <= key_low_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      gf_ff  <= gf_in;
      out_ff <= out_in;
   end

endmodule

FILE: rtl/ghash_gf128_accumulator.sv
// top level of the ghash accumulator: controller plus datapath
// depends on ghash_pkg, ghash_ctrl, ghash_dp
//
//   port group   direction  handshake          word
//   req_*        in         valid / ready      block_high, block_low, last
//   rsp_*        out        valid / ready      digest_high, digest_low
//   csr_*        in         write enable only  subkey_high (0), subkey_low (1)
//
// each word is accepted and loaded, then runs 16 passes of the
// eight-bit shift-and-add step that covers the 128 multiplier bits
// the next word is taken only after the last pass, since it needs the new hash
// a finished digest sits in the output register, so input keeps flowing while
// the consumer stalls; only a second last word waits on its final pass
// synchronous reset clears subkey, running hash and the output valid flag
`timescale 1ns / 1ps

module ghash_gf128_accumulator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [ghash_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [ghash_pkg::HalfWidth-1:0]     csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ghash_pkg::req_payload_type          req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ghash_pkg::rsp_payload_type          rsp_payload
);

   // command and status between controller and datapath
   ghash_pkg::cmd_type    cmd;
   ghash_pkg::status_type status;

   ghash_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_last  (req_payload.last),
      .status    (status),
      .cmd       (cmd)
   );

   ghash_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

   // an accepted word keeps the block busy for its multiply
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken again right after accept");

   // a digest only appears at the end of a word in flight
   a_digest_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready && cmd.finish && cmd.finish_last))
      else $error("digest appeared without a finished last word");

   // no multiply pass while waiting for input
   a_no_step_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!cmd.step && !cmd.finish))
      else $error("multiply pass while idle");

endmodule
